>>> src/vkv_pkg.sv
package vkv_pkg;

	localparam int NUM_KEYS_DEF        = 16;
	localparam int ENTRIES_PER_KEY_DEF = 64;
	localparam int QUEUE_DEPTH         = 2;

	localparam logic OP_SET = 1'b0;
	localparam logic OP_GET = 1'b1;

	localparam logic [1:0] STATUS_OK    = 2'd0;
	localparam logic [1:0] STATUS_FULL  = 2'd1;
	localparam logic [1:0] STATUS_ORDER = 2'd2;

	typedef struct packed {
		logic        operation;
		logic [3:0]  key_index;
		logic [30:0] stamp;
		logic [31:0] data_word;
	} req_item_t;

	typedef struct packed {
		logic        found;
		logic [31:0] result_word;
		logic [1:0]  status;
	} rsp_item_t;

	// classified item handed from front to back
	typedef struct packed {
		logic        is_get;
		logic        in_range;
		logic [3:0]  key_index;
		logic [30:0] stamp;
		logic [31:0] data_word;
	} cmd_t;

	typedef struct packed {
		logic full;
		logic empty;
	} queue_status_t;

endpackage

>>> src/vkv_front.sv
module vkv_front import vkv_pkg::*; #(
	parameter int NUM_KEYS = NUM_KEYS_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          req_valid,
	output logic          req_stall,
	input  req_item_t     req_item,
	input  logic          clearing,
	input  queue_status_t q_status,
	output logic          push,
	output cmd_t          push_cmd
);

	logic      valid_s1;
	req_item_t item_s1;
	logic      accept;

	assign push      = valid_s1 & ~q_status.full;
	assign req_stall = clearing | (valid_s1 & q_status.full);
	assign accept    = req_valid & ~req_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (push) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			item_s1 <= req_item;
		end
	end

	// classify: operation and whether the key exists
	always_comb begin
		push_cmd.is_get    = (item_s1.operation == OP_GET);
		push_cmd.in_range  = (32'(item_s1.key_index) < NUM_KEYS);
		push_cmd.key_index = item_s1.key_index;
		push_cmd.stamp     = item_s1.stamp;
		push_cmd.data_word = item_s1.data_word;
	end

endmodule

>>> src/vkv_queue.sv
module vkv_queue import vkv_pkg::*; (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  cmd_t          push_cmd,
	input  logic          pop,
	output cmd_t          head,
	output queue_status_t q_status
);

	localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int NW = $clog2(QUEUE_DEPTH + 1);

	cmd_t          slot_q [QUEUE_DEPTH];
	logic [PW-1:0] wr_q;
	logic [PW-1:0] rd_q;
	logic [NW-1:0] fill_q;

	assign head           = slot_q[rd_q];
	assign q_status.full  = (fill_q == NW'(QUEUE_DEPTH));
	assign q_status.empty = (fill_q == '0);

	function automatic logic [PW-1:0] wrap_inc(input logic [PW-1:0] p);
		return (p == PW'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q   <= '0;
			rd_q   <= '0;
			fill_q <= '0;
		end else begin
			if (push) begin
				wr_q <= wrap_inc(wr_q);
			end
			if (pop) begin
				rd_q <= wrap_inc(rd_q);
			end
			if (push && !pop) begin
				fill_q <= fill_q + 1'b1;
			end else if (pop && !push) begin
				fill_q <= fill_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_q] <= push_cmd;
		end
	end

endmodule

>>> src/vkv_back.sv
module vkv_back import vkv_pkg::*; #(
	parameter int NUM_KEYS        = NUM_KEYS_DEF,
	parameter int ENTRIES_PER_KEY = ENTRIES_PER_KEY_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	input  queue_status_t q_status,
	input  cmd_t          head,
	output logic          pop,
	output logic          clearing,
	output logic          rsp_valid,
	input  logic          rsp_stall,
	output rsp_item_t     rsp_item
);

	localparam int KW    = (NUM_KEYS > 1) ? $clog2(NUM_KEYS) : 1;
	localparam int IW    = (ENTRIES_PER_KEY > 1) ? $clog2(ENTRIES_PER_KEY) : 1;
	localparam int CW    = $clog2(ENTRIES_PER_KEY + 1);
	localparam int DEPTH = NUM_KEYS << IW;
	localparam int AW    = KW + IW;

	localparam logic [2:0] ST_CLEAR = 3'd0;
	localparam logic [2:0] ST_IDLE  = 3'd1;
	localparam logic [2:0] ST_USE   = 3'd2;
	localparam logic [2:0] ST_CHK   = 3'd3;
	localparam logic [2:0] ST_SRCH  = 3'd4;

	logic [CW-1:0] cnt_mem   [NUM_KEYS];
	logic [30:0]   stamp_mem [DEPTH];
	logic [31:0]   word_mem  [DEPTH];

	logic [2:0]    state_q, state_d;
	logic [KW-1:0] clr_q;
	cmd_t          cmd_q;
	logic [CW-1:0] cnt_rd_q;
	logic [30:0]   stamp_rd_q;
	logic [31:0]   word_rd_q;
	logic [CW-1:0] lo_q, lo_d, hi_q, hi_d, mid_q, mid_d;
	logic          hit_q, hit_d;
	logic [31:0]   best_q, best_d;
	logic          out_valid_q;
	rsp_item_t     out_q;

	logic [KW-1:0] kidx;
	logic [AW-1:0] wr_addr, rd_addr;
	logic [IW-1:0] rd_idx;
	logic          rd_en, wr_en, cnt_we, done;
	logic [KW-1:0] cnt_wa;
	logic [CW-1:0] cnt_wd;
	rsp_item_t     res;
	logic [CW-1:0] n_m1, mid0;
	logic          le;
	logic [CW-1:0] lo_n, hi_n, mid_n;

	assign kidx     = KW'(cmd_q.key_index);
	assign wr_addr  = {kidx, cnt_rd_q[IW-1:0]};
	assign rd_addr  = {kidx, rd_idx};
	assign clearing = (state_q == ST_CLEAR);
	assign pop      = (state_q == ST_IDLE) && !q_status.empty && (!out_valid_q || !rsp_stall);

	assign n_m1  = cnt_rd_q - 1'b1;
	assign mid0  = cnt_rd_q >> 1;
	// one probe per cycle: fold the returned stamp, then pick the next midpoint
	assign le    = (stamp_rd_q <= cmd_q.stamp);
	assign lo_n  = le ? mid_q + 1'b1 : lo_q;
	assign hi_n  = le ? hi_q : mid_q;
	assign mid_n = lo_n + ((hi_n - lo_n) >> 1);

	always_comb begin
		state_d = state_q;
		lo_d    = lo_q;
		hi_d    = hi_q;
		mid_d   = mid_q;
		hit_d   = hit_q;
		best_d  = best_q;
		rd_en   = 1'b0;
		rd_idx  = '0;
		wr_en   = 1'b0;
		cnt_we  = 1'b0;
		cnt_wa  = kidx;
		cnt_wd  = cnt_rd_q + 1'b1;
		done    = 1'b0;
		res     = '0;
		case (state_q)
			ST_CLEAR: begin
				cnt_we = 1'b1;
				cnt_wa = clr_q;
				cnt_wd = '0;
				if (clr_q == KW'(NUM_KEYS - 1)) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				if (pop) begin
					state_d = ST_USE;
				end
			end
			ST_USE: begin
				if (!cmd_q.in_range) begin
					done       = 1'b1;
					res.status = cmd_q.is_get ? STATUS_OK : STATUS_FULL;
					state_d    = ST_IDLE;
				end else if (!cmd_q.is_get) begin
					if (cnt_rd_q >= CW'(ENTRIES_PER_KEY)) begin
						done       = 1'b1;
						res.status = STATUS_FULL;
						state_d    = ST_IDLE;
					end else if (cnt_rd_q == '0) begin
						wr_en   = 1'b1;
						cnt_we  = 1'b1;
						done    = 1'b1;
						state_d = ST_IDLE;
					end else begin
						rd_en   = 1'b1;
						rd_idx  = n_m1[IW-1:0];
						state_d = ST_CHK;
					end
				end else begin
					if (cnt_rd_q == '0) begin
						done    = 1'b1;
						state_d = ST_IDLE;
					end else begin
						lo_d    = '0;
						hi_d    = cnt_rd_q;
						mid_d   = mid0;
						hit_d   = 1'b0;
						rd_en   = 1'b1;
						rd_idx  = mid0[IW-1:0];
						state_d = ST_SRCH;
					end
				end
			end
			ST_CHK: begin
				done    = 1'b1;
				state_d = ST_IDLE;
				if (cmd_q.stamp <= stamp_rd_q) begin
					res.status = STATUS_ORDER;
				end else begin
					wr_en  = 1'b1;
					cnt_we = 1'b1;
				end
			end
			ST_SRCH: begin
				lo_d = lo_n;
				hi_d = hi_n;
				if (le) begin
					hit_d  = 1'b1;
					best_d = word_rd_q;
				end
				if (lo_n < hi_n) begin
					mid_d  = mid_n;
					rd_en  = 1'b1;
					rd_idx = mid_n[IW-1:0];
				end else begin
					done            = 1'b1;
					res.found       = hit_d;
					res.result_word = hit_d ? best_d : 32'd0;
					state_d         = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			clr_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_CLEAR) begin
				clr_q <= clr_q + 1'b1;
			end
			if (done) begin
				out_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			cmd_q <= head;
		end
		lo_q   <= lo_d;
		hi_q   <= hi_d;
		mid_q  <= mid_d;
		hit_q  <= hit_d;
		best_q <= best_d;
		if (done) begin
			out_q <= res;
		end
	end

	// per-key entry counts
	always_ff @(posedge clk) begin
		if (cnt_we) begin
			cnt_mem[cnt_wa] <= cnt_wd;
		end
		if (pop) begin
			cnt_rd_q <= cnt_mem[KW'(head.key_index)];
		end
	end

	// entry stamps and words
	always_ff @(posedge clk) begin
		if (wr_en) begin
			stamp_mem[wr_addr] <= cmd_q.stamp;
			word_mem[wr_addr]  <= cmd_q.data_word;
		end
		if (rd_en) begin
			stamp_rd_q <= stamp_mem[rd_addr];
			word_rd_q  <= word_mem[rd_addr];
		end
	end

	assign rsp_valid = out_valid_q;
	assign rsp_item  = out_q;

endmodule

>>> src/versioned_key_value_store.sv
// channel   dir  handshake             payload
// req       in   req_valid/req_stall   req_item (operation, key_index, stamp, data_word)
// rsp       out  rsp_valid/rsp_stall   rsp_item (found, result_word, status)
//
// One result item per request item, in order. After the front register and queue,
// a set reads the key's count and, when the key already holds entries, checks the last
// stamp before it appends; a get runs a binary search over the key's entries, with
// one stamp-memory probe per cycle.
// After reset the per-key counts are zeroed, one key a cycle, with req_stall high until
// all NUM_KEYS keys are cleared. rsp_stall holds the output register; the back part then
// stops taking from the queue, and the front stalls once the queue and its register fill.
module versioned_key_value_store import vkv_pkg::*; #(
	parameter int NUM_KEYS        = NUM_KEYS_DEF,
	parameter int ENTRIES_PER_KEY = ENTRIES_PER_KEY_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      req_valid,
	output logic      req_stall,
	input  req_item_t req_item,
	output logic      rsp_valid,
	input  logic      rsp_stall,
	output rsp_item_t rsp_item
);

	// front -> queue
	logic          push;
	cmd_t          push_cmd;
	// queue -> back
	logic          pop;
	cmd_t          head;
	queue_status_t q_status;
	// back is sweeping the count memory after reset
	logic          clearing;

	vkv_front #(
		.NUM_KEYS(NUM_KEYS)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.req_valid(req_valid),
		.req_stall(req_stall),
		.req_item (req_item),
		.clearing (clearing),
		.q_status (q_status),
		.push     (push),
		.push_cmd (push_cmd)
	);

	vkv_queue u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.push_cmd(push_cmd),
		.pop     (pop),
		.head    (head),
		.q_status(q_status)
	);

	// count lookup, append check and binary search
	vkv_back #(
		.NUM_KEYS       (NUM_KEYS),
		.ENTRIES_PER_KEY(ENTRIES_PER_KEY)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.q_status (q_status),
		.head     (head),
		.pop      (pop),
		.clearing (clearing),
		.rsp_valid(rsp_valid),
		.rsp_stall(rsp_stall),
		.rsp_item (rsp_item)
	);

endmodule
